// ===== hw/rtl/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbs_pkg
// shared types and constants for the merge and bubble sort block
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== hw/rtl/mbs_mem.sv =====
// ----------------------------------------------------------------------------
// mbs_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mbs_mem
    import mbs_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW = $clog2(CAPACITY)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  data_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output data_t         rd_data
);

    data_t mem [CAPACITY];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mbs_seq.sv =====
// ----------------------------------------------------------------------------
// mbs_seq
// load, sort and emit sequencer: drives the element store and holds the
// result register
// ----------------------------------------------------------------------------
module mbs_seq
    import mbs_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  data_t         element_value,
    input  logic          end_of_set,
    output logic          out_valid,
    input  logic          out_ready,
    output data_t         sorted_value,
    output logic          last_result,
    output logic          overflowed,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output data_t         mem_wr_data,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  data_t         mem_rd_data
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FIRST,
        S_SECOND,
        S_PASS,
        S_TAIL,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          set_ovf_reg, set_ovf_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] emit_last_reg, emit_last_next;
    data_t         cur_reg, cur_next;
    logic          out_valid_reg, out_valid_next;
    data_t         out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          in_fire;
    logic          out_fire;
    logic          full;
    logic [CW-1:0] count_new;
    logic [AW-1:0] top_idx;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign count_new = full ? count_reg : count_reg + CW'(1);
    assign top_idx   = AW'(count_new - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        set_ovf_next   = set_ovf_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        emit_last_next = emit_last_reg;
        cur_next       = cur_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = cur_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (!full)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(count_reg);
                        mem_wr_data = element_value;
                    end
                    count_next = count_new;
                    ovf_next   = ovf_reg | full;
                    if (end_of_set)
                    begin
                        set_ovf_next   = ovf_reg | full;
                        emit_last_next = top_idx;
                        lim_next       = top_idx;
                        idx_next       = '0;
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        state_next     = (top_idx == '0) ? S_EMIT_RD : S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_next  = S_SECOND;
            end
            S_SECOND:
            begin
                cur_next    = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(1);
                idx_next    = AW'(1);
                state_next  = S_PASS;
            end
            S_PASS:
            begin
                // carry the larger value forward, drop the smaller one behind
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg - AW'(1);
                if (cur_reg > mem_rd_data)
                begin
                    mem_wr_data = mem_rd_data;
                end
                else
                begin
                    mem_wr_data = cur_reg;
                    cur_next    = mem_rd_data;
                end
                if (idx_reg == lim_reg)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + AW'(1);
                    idx_next    = idx_reg + AW'(1);
                end
            end
            S_TAIL:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = lim_reg;
                mem_wr_data = cur_reg;
                if (lim_reg == AW'(1))
                begin
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    lim_next   = lim_reg - AW'(1);
                    state_next = S_FIRST;
                end
            end
            S_EMIT_RD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg;
                    state_next  = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_value_next = mem_rd_data;
                out_last_next  = (idx_reg == emit_last_reg);
                out_ovf_next   = set_ovf_reg;
                if (idx_reg == emit_last_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_ovf_reg   <= set_ovf_next;
        lim_reg       <= lim_next;
        idx_reg       <= idx_next;
        emit_last_reg <= emit_last_next;
        cur_reg       <= cur_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ===== hw/rtl/merge_and_bubble_sort_top.sv =====
// ----------------------------------------------------------------------------
// merge_and_bubble_sort_top
// gathers a set of signed 32-bit elements, bubble sorts them in a one-read
// one-write memory and streams them out in ascending order
// ----------------------------------------------------------------------------
// input channel: one element per transaction, end_of_set closes the set;
//   in_ready is high only while loading, so loading runs at one per cycle
// elements past CAPACITY are dropped and every result of that set is flagged
// sorting: each pass streams the unsorted part of the store once, read one
//   entry and write one entry back per cycle
// output channel: one result per transaction, read from the store and then
//   loaded into the result register; last_result marks the largest element
// a stalled receiver holds the result register; sorting is finished by then
//   and the sequencer simply waits; the last result may still be pending
//   while the next set loads
// reset clears the control state; the store needs no clearing
// ----------------------------------------------------------------------------
module merge_and_bubble_sort_top
    import mbs_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t element_value,
    input  logic  end_of_set,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t sorted_value,
    output logic  last_result,
    output logic  overflowed
);

    localparam int AW = $clog2(CAPACITY);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    data_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    data_t         mem_rd_data;

    mbs_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .end_of_set    (end_of_set),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_value  (sorted_value),
        .last_result   (last_result),
        .overflowed    (overflowed),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    mbs_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== hw/rtl/mbs_checker.sv =====
// ----------------------------------------------------------------------------
// mbs_checker
// port-level checks on the merge and bubble sort block
// ----------------------------------------------------------------------------
module mbs_checker
    import mbs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input data_t element_value,
    input logic  end_of_set,
    input logic  out_valid,
    input logic  out_ready,
    input data_t sorted_value,
    input logic  last_result,
    input logic  overflowed
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_value)
            && $stable(last_result) && $stable(overflowed))
        else $error("result changed while stalled");

    // no loading while a set is still being emitted
    a_emit_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> !in_ready)
        else $error("input ready during emission");

    // closing transaction ends loading and starts the sort or, for one element, the output
    a_close_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_set |=> !in_ready)
        else $error("input still ready after set closed");

    // loading continues until the set closes
    a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !end_of_set |=> in_ready)
        else $error("input stalled mid-set");

    // nothing follows the last result at once
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_result |=> !out_valid)
        else $error("result straight after last");

endmodule

bind merge_and_bubble_sort_top mbs_checker u_mbs_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for merge_and_bubble_sort_top: sets of signed elements
// go in over a valid/ready channel, a scoreboard sorts each closed set and
// compares every sorted transaction, including the last and overflow flags
// ----------------------------------------------------------------------------

class sort_scoreboard;

    typedef struct {
        mbs_pkg::data_t value;
        logic           last;
        logic           ovf;
    } sorted_t;

    int             capacity;
    mbs_pkg::data_t gathered[$];
    logic           dropped;
    sorted_t        expected_sorted[$];
    int             errors;
    int             elements_in;
    int             sets_closed;
    int             overflow_sets;
    int             results_checked;

    function new(int cap);
        capacity        = cap;
        dropped         = 1'b0;
        errors          = 0;
        elements_in     = 0;
        sets_closed     = 0;
        overflow_sets   = 0;
        results_checked = 0;
    endfunction

    function void note_element(mbs_pkg::data_t value, logic closing);
        mbs_pkg::data_t swap_tmp;
        sorted_t        entry;
        int             n;
        elements_in++;
        if (gathered.size() < capacity)
            gathered.push_back(value);
        else
            dropped = 1'b1;
        if (!closing)
            return;
        n = gathered.size();
        // ascending bubble sort, only strictly greater pairs swap
        for (int pass = 0; pass + 1 < n; pass++)
        begin
            for (int k = 0; k + 1 < n - pass; k++)
            begin
                if (gathered[k] > gathered[k + 1])
                begin
                    swap_tmp         = gathered[k];
                    gathered[k]      = gathered[k + 1];
                    gathered[k + 1]  = swap_tmp;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            entry.value = gathered[k];
            entry.last  = (k == n - 1);
            entry.ovf   = dropped;
            expected_sorted.push_back(entry);
        end
        sets_closed++;
        if (dropped)
            overflow_sets++;
        gathered.delete();
        dropped = 1'b0;
    endfunction

    function void check_result(mbs_pkg::data_t value, logic last, logic ovf);
        sorted_t exp_r;
        if (expected_sorted.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected transaction, expected none, got value %0d last %b ovf %b",
                     $time, value, last, ovf);
            return;
        end
        exp_r = expected_sorted.pop_front();
        results_checked++;
        if (value !== exp_r.value)
        begin
            errors++;
            $display("%0t: sorted_value expected %0d, got %0d", $time, exp_r.value, value);
        end
        if (last !== exp_r.last)
        begin
            errors++;
            $display("%0t: last_result expected %b, got %b", $time, exp_r.last, last);
        end
        if (ovf !== exp_r.ovf)
        begin
            errors++;
            $display("%0t: overflowed expected %b, got %b", $time, exp_r.ovf, ovf);
        end
    endfunction

endclass

module tb;

    import mbs_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int HOLD_LEN   = 3000;
    localparam int RAND_ITEMS = 250;

    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  in_valid      = 1'b0;
    logic  in_ready;
    data_t element_value = '0;
    logic  end_of_set    = 1'b0;
    logic  out_valid;
    logic  out_ready     = 1'b0;
    data_t sorted_value;
    logic  last_result;
    logic  overflowed;

    bit    calm     = 1'b0;
    bit    hold_req = 1'b0;

    sort_scoreboard board = new(CAPACITY);

    merge_and_bubble_sort_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .end_of_set    (end_of_set),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sorted_value  (sorted_value),
        .last_result   (last_result),
        .overflowed    (overflowed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return data_t'(32'h8000_0000);
                    1:       return data_t'(32'h7fff_ffff);
                    2:       return data_t'(32'h8000_0001);
                    3:       return data_t'(32'h7fff_fffe);
                    4:       return data_t'(32'hffff_ffff);
                    default: return '0;
                endcase
            end
            // narrow range so equal values meet
            1, 2:    return data_t'($urandom_range(0, 6)) - 3;
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic int pick_set_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 8);
        if (roll < 95)
            return $urandom_range(9, 40);
        return $urandom_range(CAPACITY - 2, CAPACITY + 3);
    endfunction

    task automatic send_element(input data_t value, input logic closing);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        element_value <= value;
        end_of_set    <= closing;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_element(value, closing);
    endtask

    task automatic send_set(input data_t vals[$]);
        foreach (vals[i])
            send_element(vals[i], i == vals.size() - 1);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_sorted.size() != 0);
    endtask

    // receiver side: random back-pressure plus one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(sorted_value, last_result, overflowed);
            if (hold_req)
            begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    initial
    begin
        data_t set_vals[$];
        int    set_len;
        int    sent;
        int    set_idx;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets: extremes, duplicates, reversed order, alternating bits
        set_vals = '{data_t'(32'h7fff_ffff)};
        send_set(set_vals);
        set_vals = '{data_t'(32'h8000_0000)};
        send_set(set_vals);
        set_vals = '{data_t'(32'h7fff_ffff), data_t'(0), data_t'(32'h8000_0000),
                     data_t'(-1), data_t'(1)};
        send_set(set_vals);
        set_vals = '{data_t'(5), data_t'(5), data_t'(-5), data_t'(5)};
        send_set(set_vals);
        set_vals = '{data_t'(100), data_t'(50), data_t'(0), data_t'(-50), data_t'(-100)};
        send_set(set_vals);
        set_vals = '{data_t'(32'haaaa_aaaa), data_t'(32'h5555_5555)};
        send_set(set_vals);

        hold_req = 1'b1;
        set_idx  = 0;
        sent     = 0;
        while (sent < RAND_ITEMS)
        begin
            calm = (set_idx >= 10 && set_idx < 16);
            if (set_idx == 2)
                set_len = CAPACITY;
            else if (set_idx == 5)
                set_len = CAPACITY + $urandom_range(1, 4);
            else
                set_len = pick_set_length();
            set_vals.delete();
            repeat (set_len) set_vals.push_back(pick_value());
            send_set(set_vals);
            sent += set_len;
            if (set_idx == 7)
                wait_for_drain();
            set_idx++;
        end
        calm = 1'b0;

        wait_for_drain();
        repeat (50) @(posedge clk);

        $display("covered %0d sets (%0d with dropped elements) from %0d elements",
                 board.sets_closed, board.overflow_sets, board.elements_in);
        $display("checked %0d sorted transactions under random and long back-pressure",
                 board.results_checked);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d transactions outstanding", board.expected_sorted.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_mem.sv
hw/rtl/mbs_seq.sv
hw/rtl/merge_and_bubble_sort_top.sv
hw/rtl/mbs_checker.sv
dv/tb.sv
